// ===== src/pat_pkg.sv =====
`timescale 1ns / 1ps

package pat_pkg;

    localparam int NUM_PORTS_DEF     = 65536;
    localparam int NUM_PROTOCOLS_DEF = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_EPH_LOW    = 2'd0;
    localparam logic [1:0] CFG_EPH_HIGH   = 2'd1;
    localparam logic [1:0] CFG_FREE_OWNER = 2'd2;

    localparam logic [15:0] EPH_LOW_RST    = 16'd49152;
    localparam logic [15:0] EPH_HIGH_RST   = 16'd65535;
    localparam logic [15:0] FREE_OWNER_RST = 16'd0;

    typedef enum logic [2:0] {
        MODE_ALLOC      = 3'd0,
        MODE_BIND       = 3'd1,
        MODE_UNBIND     = 3'd2,
        MODE_UNBIND_ALL = 3'd3,
        MODE_LOOKUP     = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PROTO = 2'd1,
        ST_BUSY      = 2'd2,
        ST_NOT_BOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_PROBE,
        S_PROBE_CHK,
        S_CHECK,
        S_SWEEP,
        S_DONE
    } state_t;

    // One table entry as held in the memory
    typedef struct packed {
        logic        used;
        logic [15:0] owner;
        logic [15:0] handler;
    } entry_t;

    // Input beat payload, last field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] random_seed;
        logic [15:0] handler_id;
        logic [15:0] owner_id;
        logic [15:0] port_number;
        logic [1:0]  protocol;
    } in_data_t;

    // Result beat payload, last field in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [15:0] handler_result;
        logic [15:0] owner_result;
        logic        bound;
        logic [15:0] port_result;
    } out_data_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] port;
        logic        bound;
        logic [15:0] owner;
        logic [15:0] handler;
    } result_t;

endpackage

// ===== src/pat_ram.sv =====
`timescale 1ns / 1ps

module pat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/port_allocation_table_core.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake                Payload
// s_       in   s_tvalid / s_tready      s_tdata: protocol, port_number, owner_id,
//                                        handler_id, random_seed; s_tuser: mode
// m_       out  m_tvalid / m_tready      m_tdata: port_result, bound, owner_result,
//                                        handler_result; m_tuser: status
// cfg_     in   cfg_valid / cfg_ready    cfg_index, cfg_data (always ready)
//
// One item at a time; every beat gives exactly one result beat.
// Bind, unbind and lookup: dispatch, one memory read, then the write-back and
// output; a rejected protocol or port goes from dispatch straight to output, as
// do an empty range and an unused mode. Allocate: dispatch, 32-step seed
// modulo and output, plus a read and then a check per probed port, a skip with
// no read per port past the table and a last probe step when no port is free.
// Unbind all: one entry per cycle over NUM_PROTOCOLS * (NUM_PORTS - 1) entries.
// After reset a clearing pass writes all NUM_PROTOCOLS * NUM_PORTS entries, one
// a cycle, with s_tready low; configuration writes are taken throughout.
// A finished result waits in the output register, so the next beat is taken
// while m_tready is low; a second result then waits until the first is gone.

module port_allocation_table_core #(
    parameter int NUM_PORTS     = pat_pkg::NUM_PORTS_DEF,
    parameter int NUM_PROTOCOLS = pat_pkg::NUM_PROTOCOLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // protocol[1:0], port_number[17:2], owner_id[33:18],
                                   // handler_id[49:34], random_seed[81:50], zero pad
    input  logic [2:0]  s_tuser,   // mode
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // port_result[15:0], bound[16], owner_result[32:17],
                                   // handler_result[48:33], zero pad
    output logic [1:0]  m_tuser,   // status
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int TABLE_SIZE = NUM_PORTS * NUM_PROTOCOLS;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int PORT_W     = $clog2(NUM_PORTS);
    localparam int ENTRY_W    = $bits(pat_pkg::entry_t);

    // Table slot of a protocol and port
    function automatic logic [ADDR_W-1:0] slot_of(input logic [1:0] pr,
                                                  input logic [15:0] pt);
        slot_of = ADDR_W'(32'(pr) * 32'(NUM_PORTS) + 32'(pt));
    endfunction

    pat_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic [15:0] eph_low_reg, eph_high_reg, free_owner_reg;

    // Item under work
    pat_pkg::mode_t mode_reg, mode_next;
    logic [1:0]  proto_reg, proto_next;
    logic [15:0] port_reg, port_next;
    logic [15:0] owner_reg, owner_next;
    logic [15:0] handler_reg, handler_next;
    logic [31:0] seed_reg, seed_next;

    // Modulo unit and probe walk
    logic [16:0] range_reg, range_next;
    logic [15:0] rem_reg, rem_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;
    logic [15:0] idx_reg, idx_next;
    logic [16:0] left_reg, left_next;

    // Unbind-all sweep
    logic [1:0]        sw_proto_reg, sw_proto_next;
    logic [PORT_W-1:0] sw_port_reg, sw_port_next;
    logic              sw_issue_reg, sw_issue_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;

    pat_pkg::result_t res_reg, res_next;
    pat_pkg::result_t out_reg, out_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Memory ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    pat_pkg::entry_t   ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    pat_pkg::entry_t   ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    pat_pkg::in_data_t  in_data;
    pat_pkg::out_data_t out_data;

    logic        proto_ok, port_ok;
    logic [16:0] div_shift;
    logic [16:0] probe_sum;
    logic [15:0] probe_port;
    logic        probe_beyond;
    logic [16:0] idx_inc;
    logic [15:0] idx_adv;

    pat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = pat_pkg::entry_t'(ram_rdata_raw);

    assign in_data   = pat_pkg::in_data_t'(s_tdata);
    assign s_tready  = (state_reg == pat_pkg::S_IDLE);
    assign cfg_ready = 1'b1;

    assign out_data.pad            = '0;
    assign out_data.handler_result = out_reg.handler;
    assign out_data.owner_result   = out_reg.owner;
    assign out_data.bound          = out_reg.bound;
    assign out_data.port_result    = out_reg.port;
    assign m_tdata  = out_data;
    assign m_tuser  = out_reg.status;
    assign m_tvalid = m_tvalid_reg;

    assign proto_ok = (3'(proto_reg) < 3'(NUM_PROTOCOLS));
    assign port_ok  = ({1'b0, port_reg} < 17'(NUM_PORTS));

    // One restoring step: shift in the next seed bit, subtract the range if it fits
    assign div_shift = {rem_reg, seed_reg[31]};

    // Probe candidate; low + idx never exceeds the range top, so 16 bits hold it
    assign probe_sum    = 17'(eph_low_reg) + 17'(idx_reg);
    assign probe_port   = probe_sum[15:0];
    assign probe_beyond = (probe_sum >= 17'(NUM_PORTS));
    assign idx_inc      = 17'(idx_reg) + 17'd1;
    assign idx_adv      = (idx_inc == range_reg) ? 16'd0 : idx_inc[15:0];

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pat_pkg::S_CLEAR;
            clr_addr_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            sw_issue_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            eph_low_reg    <= pat_pkg::EPH_LOW_RST;
            eph_high_reg   <= pat_pkg::EPH_HIGH_RST;
            free_owner_reg <= pat_pkg::FREE_OWNER_RST;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
            sw_issue_reg <= sw_issue_next;
            pend_reg     <= pend_next;
            if (cfg_valid) begin
                case (cfg_index)
                    pat_pkg::CFG_EPH_LOW:    eph_low_reg    <= cfg_data;
                    pat_pkg::CFG_EPH_HIGH:   eph_high_reg   <= cfg_data;
                    pat_pkg::CFG_FREE_OWNER: free_owner_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        proto_reg     <= proto_next;
        port_reg      <= port_next;
        owner_reg     <= owner_next;
        handler_reg   <= handler_next;
        seed_reg      <= seed_next;
        range_reg     <= range_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        idx_reg       <= idx_next;
        left_reg      <= left_next;
        sw_proto_reg  <= sw_proto_next;
        sw_port_reg   <= sw_port_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        mode_next      = mode_reg;
        proto_next     = proto_reg;
        port_next      = port_reg;
        owner_next     = owner_reg;
        handler_next   = handler_reg;
        seed_next      = seed_reg;
        range_next     = range_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        idx_next       = idx_reg;
        left_next      = left_reg;
        sw_proto_next  = sw_proto_reg;
        sw_port_next   = sw_port_reg;
        sw_issue_next  = sw_issue_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        m_tvalid_next  = m_tvalid_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        // Drop the result once the downstream side takes it
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            pat_pkg::S_CLEAR: begin
                // Reset the table one entry a cycle
                ram_we          = 1'b1;
                ram_waddr       = clr_addr_reg;
                ram_wdata.owner = pat_pkg::FREE_OWNER_RST;
                if (clr_addr_reg == ADDR_W'(TABLE_SIZE - 1)) begin
                    state_next = pat_pkg::S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            pat_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    mode_next    = pat_pkg::mode_t'(s_tuser);
                    proto_next   = in_data.protocol;
                    port_next    = in_data.port_number;
                    owner_next   = in_data.owner_id;
                    handler_next = in_data.handler_id;
                    seed_next    = in_data.random_seed;
                    state_next   = pat_pkg::S_DISPATCH;
                end
            end

            pat_pkg::S_DISPATCH: begin
                res_next.status  = pat_pkg::ST_OK;
                res_next.port    = port_reg;
                res_next.bound   = 1'b0;
                res_next.owner   = '0;
                res_next.handler = '0;
                state_next       = pat_pkg::S_DONE;
                case (mode_reg)
                    pat_pkg::MODE_ALLOC: begin
                        if (!proto_ok) begin
                            res_next.status = pat_pkg::ST_BAD_PROTO;
                        end else if (eph_high_reg < eph_low_reg) begin
                            res_next.status = pat_pkg::ST_BUSY;
                        end else begin
                            range_next   = {1'b0, eph_high_reg} - {1'b0, eph_low_reg} + 17'd1;
                            rem_next     = '0;
                            div_cnt_next = '1;
                            state_next   = pat_pkg::S_DIV;
                        end
                    end
                    pat_pkg::MODE_BIND, pat_pkg::MODE_UNBIND, pat_pkg::MODE_LOOKUP: begin
                        if (mode_reg == pat_pkg::MODE_LOOKUP) begin
                            res_next.owner = free_owner_reg;
                        end
                        if (!proto_ok) begin
                            res_next.status = pat_pkg::ST_BAD_PROTO;
                        end else if (!port_ok) begin
                            // No entry behind this port
                            if (mode_reg == pat_pkg::MODE_BIND) begin
                                res_next.status = pat_pkg::ST_BUSY;
                            end else if (mode_reg == pat_pkg::MODE_UNBIND) begin
                                res_next.status = pat_pkg::ST_NOT_BOUND;
                            end
                        end else begin
                            ram_raddr  = slot_of(proto_reg, port_reg);
                            state_next = pat_pkg::S_CHECK;
                        end
                    end
                    pat_pkg::MODE_UNBIND_ALL: begin
                        sw_proto_next = '0;
                        sw_port_next  = PORT_W'(1);
                        sw_issue_next = 1'b1;
                        pend_next     = 1'b0;
                        state_next    = pat_pkg::S_SWEEP;
                    end
                    default: ;
                endcase
            end

            pat_pkg::S_DIV: begin
                if (div_shift >= range_reg) begin
                    rem_next = 16'(div_shift - range_reg);
                end else begin
                    rem_next = div_shift[15:0];
                end
                seed_next = {seed_reg[30:0], 1'b0};
                if (div_cnt_reg == '0) begin
                    idx_next   = rem_next;
                    left_next  = range_reg;
                    state_next = pat_pkg::S_PROBE;
                end else begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end

            pat_pkg::S_PROBE: begin
                if (left_reg == '0) begin
                    res_next.status = pat_pkg::ST_BUSY;
                    state_next      = pat_pkg::S_DONE;
                end else if (probe_beyond) begin
                    // Skip ports past the table without a read
                    idx_next  = idx_adv;
                    left_next = left_reg - 1'b1;
                end else begin
                    ram_raddr  = slot_of(proto_reg, probe_port);
                    state_next = pat_pkg::S_PROBE_CHK;
                end
            end

            pat_pkg::S_PROBE_CHK: begin
                if (!ram_rdata.used) begin
                    ram_we            = 1'b1;
                    ram_waddr         = slot_of(proto_reg, probe_port);
                    ram_wdata.used    = 1'b1;
                    ram_wdata.owner   = owner_reg;
                    ram_wdata.handler = handler_reg;
                    res_next.status   = pat_pkg::ST_OK;
                    res_next.port     = probe_port;
                    state_next        = pat_pkg::S_DONE;
                end else begin
                    idx_next   = idx_adv;
                    left_next  = left_reg - 1'b1;
                    state_next = pat_pkg::S_PROBE;
                end
            end

            pat_pkg::S_CHECK: begin
                ram_waddr  = slot_of(proto_reg, port_reg);
                state_next = pat_pkg::S_DONE;
                case (mode_reg)
                    pat_pkg::MODE_BIND: begin
                        if (ram_rdata.used) begin
                            res_next.status = pat_pkg::ST_BUSY;
                        end else begin
                            ram_we            = 1'b1;
                            ram_wdata.used    = 1'b1;
                            ram_wdata.owner   = owner_reg;
                            ram_wdata.handler = handler_reg;
                        end
                    end
                    pat_pkg::MODE_UNBIND: begin
                        if (!ram_rdata.used || ram_rdata.owner != owner_reg) begin
                            res_next.status = pat_pkg::ST_NOT_BOUND;
                        end else begin
                            ram_we          = 1'b1;
                            ram_wdata.owner = free_owner_reg;
                        end
                    end
                    pat_pkg::MODE_LOOKUP: begin
                        res_next.bound   = ram_rdata.used;
                        res_next.owner   = ram_rdata.owner;
                        res_next.handler = ram_rdata.used ? ram_rdata.handler : 16'd0;
                    end
                    default: ;
                endcase
            end

            pat_pkg::S_SWEEP: begin
                // Write back the entry read last cycle; read the next one
                if (pend_reg && ram_rdata.used && ram_rdata.owner == owner_reg) begin
                    ram_we          = 1'b1;
                    ram_waddr       = pend_addr_reg;
                    ram_wdata.owner = free_owner_reg;
                end
                if (sw_issue_reg) begin
                    ram_raddr      = slot_of(sw_proto_reg, 16'(sw_port_reg));
                    pend_next      = 1'b1;
                    pend_addr_next = ram_raddr;
                    if (sw_port_reg == PORT_W'(NUM_PORTS - 1)) begin
                        sw_port_next = PORT_W'(1);
                        if (sw_proto_reg == 2'(NUM_PROTOCOLS - 1)) begin
                            sw_issue_next = 1'b0;
                        end else begin
                            sw_proto_next = sw_proto_reg + 1'b1;
                        end
                    end else begin
                        sw_port_next = sw_port_reg + 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = pat_pkg::S_DONE;
                    end
                end
            end

            pat_pkg::S_DONE: begin
                // Hold until the output register is free or being emptied
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = pat_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = pat_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pat_checker.sv =====
`timescale 1ns / 1ps

module pat_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    pat_pkg::out_data_t out_data;

    assign out_data = pat_pkg::out_data_t'(m_tdata);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Reset empties the output and blocks input during the clearing pass
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("output or input open straight after reset");

    // One item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while an item is at work");

    // A free port never reports a handler
    a_free_handler: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_data.bound |-> out_data.handler_result == 16'd0)
        else $error("handler reported for an unbound port");

    // A failed operation never reports a bound port
    a_fail_unbound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != pat_pkg::ST_OK |-> !out_data.bound)
        else $error("bound flag set on a failed operation");

endmodule

bind port_allocation_table_core pat_checker u_pat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/tb_port_allocation_table_core.sv =====
`timescale 1ns / 1ps

module tb_port_allocation_table_core;

    import pat_pkg::*;

    // Mode codes that the block has no operation for; they must be answered as no-ops
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int TABLE_SLOTS = NUM_PORTS_DEF * NUM_PROTOCOLS_DEF;

    // A full unbind-all sweep or the clearing pass after reset visits every table
    // slot with no beat moving; the limit leaves ample room for either.
    localparam int QUIET_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 305;

    // Port table predictor and store of awaited replies
    class port_table_model;
        bit        used_flag   [TABLE_SLOTS];
        bit [15:0] owner_tab   [TABLE_SLOTS];
        bit [15:0] handler_tab [TABLE_SLOTS];
        bit [15:0] eph_low;
        bit [15:0] eph_high;
        bit [15:0] free_owner;
        result_t   awaited_replies[$];
        int        mismatch_count;

        function new();
            eph_low        = EPH_LOW_RST;
            eph_high       = EPH_HIGH_RST;
            free_owner     = FREE_OWNER_RST;
            mismatch_count = 0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                used_flag[i]   = 1'b0;
                owner_tab[i]   = FREE_OWNER_RST;
                handler_tab[i] = '0;
            end
        endfunction

        function int slot(logic [1:0] proto, logic [15:0] port);
            return int'(proto) * NUM_PORTS_DEF + int'(port);
        endfunction

        function void claim(int s, logic [15:0] owner, logic [15:0] handler);
            used_flag[s]   = 1'b1;
            owner_tab[s]   = owner;
            handler_tab[s] = handler;
        endfunction

        // A freed entry takes the free code in force at the moment it is freed
        function void release_slot(int s);
            used_flag[s]   = 1'b0;
            owner_tab[s]   = free_owner;
            handler_tab[s] = '0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_EPH_LOW:    eph_low    = value;
                CFG_EPH_HIGH:   eph_high   = value;
                CFG_FREE_OWNER: free_owner = value;
                default: ;
            endcase
        endfunction

        function logic [15:0] owner_at(logic [1:0] proto, logic [15:0] port);
            if (int'(proto) >= NUM_PROTOCOLS_DEF)
                return free_owner;
            return owner_tab[slot(proto, port)];
        endfunction

        function int outstanding();
            return awaited_replies.size();
        endfunction

        // Apply one accepted request and queue the reply it must produce
        function void note_request(logic [2:0] mode, logic [1:0] proto, logic [15:0] port,
                                   logic [15:0] owner, logic [15:0] handler,
                                   logic [31:0] seed);
            result_t     r;
            bit          proto_ok;
            bit          port_ok;
            bit          found;
            int          s;
            int unsigned span;
            int unsigned start;
            int unsigned p;
            proto_ok  = int'(proto) < NUM_PROTOCOLS_DEF;
            port_ok   = int'(port) < NUM_PORTS_DEF;
            r.status  = ST_OK;
            r.port    = port;
            r.bound   = 1'b0;
            r.owner   = '0;
            r.handler = '0;
            case (mode)
                MODE_ALLOC: begin
                    if (!proto_ok) begin
                        r.status = ST_BAD_PROTO;
                    end else if (eph_high < eph_low) begin
                        r.status = ST_BUSY;
                    end else begin
                        // linear probe with wrap from low + seed mod span
                        span     = int'(eph_high) - int'(eph_low) + 1;
                        start    = seed % span;
                        found    = 1'b0;
                        r.status = ST_BUSY;
                        for (int unsigned i = 0; i < span && !found; i++) begin
                            p = int'(eph_low) + (start + i) % span;
                            if (p < NUM_PORTS_DEF) begin
                                s = slot(proto, p[15:0]);
                                if (!used_flag[s]) begin
                                    claim(s, owner, handler);
                                    r.status = ST_OK;
                                    r.port   = p[15:0];
                                    found    = 1'b1;
                                end
                            end
                        end
                    end
                end
                MODE_BIND: begin
                    if (!proto_ok)
                        r.status = ST_BAD_PROTO;
                    else if (!port_ok || used_flag[slot(proto, port)])
                        r.status = ST_BUSY;
                    else
                        claim(slot(proto, port), owner, handler);
                end
                MODE_UNBIND: begin
                    if (!proto_ok) begin
                        r.status = ST_BAD_PROTO;
                    end else if (!port_ok) begin
                        r.status = ST_NOT_BOUND;
                    end else begin
                        s = slot(proto, port);
                        if (!used_flag[s] || owner_tab[s] != owner)
                            r.status = ST_NOT_BOUND;
                        else
                            release_slot(s);
                    end
                end
                MODE_UNBIND_ALL: begin
                    // every protocol, port 0 left alone
                    for (int pr = 0; pr < NUM_PROTOCOLS_DEF; pr++) begin
                        for (int q = 1; q < NUM_PORTS_DEF; q++) begin
                            s = pr * NUM_PORTS_DEF + q;
                            if (used_flag[s] && owner_tab[s] == owner)
                                release_slot(s);
                        end
                    end
                end
                MODE_LOOKUP: begin
                    r.owner = free_owner;
                    if (!proto_ok) begin
                        r.status = ST_BAD_PROTO;
                    end else if (port_ok) begin
                        s         = slot(proto, port);
                        r.bound   = used_flag[s];
                        r.owner   = owner_tab[s];
                        r.handler = used_flag[s] ? handler_tab[s] : 16'h0000;
                    end
                end
                default: ;
            endcase
            awaited_replies.push_back(r);
        endfunction

        function void check_reply(result_t got);
            result_t want;
            if (awaited_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reply: status %0d port %0d bound %0d owner %h handler %h",
                             got.status, got.port, got.bound, got.owner, got.handler);
                return;
            end
            want = awaited_replies.pop_front();
            if (got.status !== want.status || got.port !== want.port ||
                got.bound !== want.bound || got.owner !== want.owner ||
                got.handler !== want.handler) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $write("reply mismatch: expected status %0d port %0d bound %0d owner %h ",
                           want.status, want.port, want.bound, want.owner);
                    $display("handler %h, got status %0d port %0d bound %0d owner %h handler %h",
                             want.handler, got.status, got.port, got.bound, got.owner,
                             got.handler);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;   // protocol, port_number, owner_id, handler_id, random_seed
    logic [2:0]  s_tuser   = '0;   // mode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;          // port_result, bound, owner_result, handler_result
    logic [1:0]  m_tuser;          // status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    port_table_model port_table;

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          quiet_cycles   = 0;
    logic [15:0] cur_low        = EPH_LOW_RST;
    logic [15:0] owner_pool [8];
    logic [15:0] port_pool  [16];

    port_allocation_table_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Collect reply beats and stall the master side at random
    always @(posedge aclk) begin : collect_replies
        out_data_t reply_bits;
        result_t   got;
        if (m_tvalid === 1'b1 && m_tready) begin
            reply_bits  = m_tdata;
            got.status  = status_t'(m_tuser);
            got.port    = reply_bits.port_result;
            got.bound   = reply_bits.bound;
            got.owner   = reply_bits.owner_result;
            got.handler = reply_bits.handler_result;
            port_table.check_reply(got);
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: end the run if no beat moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
            (cfg_valid && cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("port_allocation_table_core regression: fail");
                $finish;
            end
        end
    end

    // Present one request beat and hold it until taken. Valid is left high so
    // that a following beat can go out back to back; drop it on an idle gap.
    task automatic send_request(input logic [2:0] mode, input logic [1:0] proto,
                                input logic [15:0] port, input logic [15:0] owner,
                                input logic [15:0] handler, input logic [31:0] seed);
        in_data_t beat;
        beat             = '0;
        beat.protocol    = proto;
        beat.port_number = port;
        beat.owner_id    = owner;
        beat.handler_id  = handler;
        beat.random_seed = seed;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tuser  <= mode;
        do @(posedge aclk); while (s_tready !== 1'b1);
        port_table.note_request(mode, proto, port, owner, handler, seed);
    endtask

    // Hold off the sender until every awaited reply has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (port_table.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        port_table.set_register(idx, value);
    endtask

    // Registers change only with the block idle
    task automatic write_settings(input logic [15:0] low, input logic [15:0] high,
                                  input logic [15:0] free_code);
        wait_drained();
        write_register(CFG_EPH_LOW, low);
        write_register(CFG_EPH_HIGH, high);
        write_register(CFG_FREE_OWNER, free_code);
        cfg_valid <= 1'b0;
        cur_low = low;
    endtask

    // Mostly well-formed traffic on a small set of owners and ports, so that
    // binds collide, unbinds find their owner and lookups hit claimed entries
    task automatic send_mixed_item();
        logic [2:0]  mode;
        logic [1:0]  proto;
        logic [15:0] port;
        logic [15:0] owner;
        logic [15:0] handler;
        logic [31:0] seed;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 25)
            mode = MODE_ALLOC;
        else if (pick < 50)
            mode = MODE_BIND;
        else if (pick < 70)
            mode = MODE_UNBIND;
        else
            mode = MODE_LOOKUP;
        proto = ($urandom_range(9) == 0) ? 2'($urandom_range(3))
                                         : 2'($urandom_range(NUM_PROTOCOLS_DEF - 1));
        pick = $urandom_range(9);
        if (pick < 4)
            port = port_pool[$urandom_range(15)];
        else if (pick < 7)
            port = cur_low + 16'($urandom_range(15));   // where clustered allocations land
        else
            port = 16'($urandom);
        owner = ($urandom_range(9) < 7) ? owner_pool[$urandom_range(7)] : 16'($urandom);
        if (mode == MODE_UNBIND && $urandom_range(9) < 7)
            owner = port_table.owner_at(proto, port);
        handler = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom);
        seed    = $urandom_range(1) ? 32'($urandom_range(15)) : 32'($urandom);
        send_request(mode, proto, port, owner, handler, seed);
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input logic [15:0] low,
                             input logic [15:0] high, input logic [15:0] free_code,
                             input bit with_sweep);
        write_settings(low, high, free_code);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        foreach (owner_pool[i])
            owner_pool[i] = 16'($urandom);
        foreach (port_pool[i])
            port_pool[i] = 16'($urandom);
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // one sweep in the middle; it holds the block for a whole table pass
            if (with_sweep && n == PHASE_ITEMS / 2)
                send_request(MODE_UNBIND_ALL, 2'($urandom_range(3)), 16'($urandom),
                             owner_pool[$urandom_range(7)], 16'($urandom), $urandom);
            else
                send_mixed_item();
            if ($urandom_range(99) == 0)
                wait_drained();
        end
    endtask

    initial begin
        port_table = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under reset settings; the first beat waits out the clearing pass
        send_request(MODE_LOOKUP, 2'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0);
        send_request(MODE_BIND, 2'd0, 16'h0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(MODE_BIND, 2'd0, 16'h0000, 16'h0001, 16'h0001, 32'h0);      // in use
        send_request(MODE_LOOKUP, 2'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0);
        send_request(MODE_BIND, 2'd1, 16'hFFFF, 16'h1234, 16'h0000, 32'h0);
        send_request(MODE_BIND, 2'd2, 16'h0005, 16'h1234, 16'h0001, 32'h0);      // bad protocol
        send_request(MODE_LOOKUP, 2'd3, 16'h0000, 16'h0000, 16'h0000, 32'h0);
        send_request(MODE_ALLOC, 2'd0, 16'h0000, 16'h00AA, 16'h5555, 32'hFFFF_FFFF);
        send_request(MODE_ALLOC, 2'd3, 16'h0042, 16'h00AA, 16'h5555, 32'h0);
        send_request(MODE_UNBIND, 2'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0);    // wrong owner
        send_request(MODE_UNBIND, 2'd1, 16'hFFFF, 16'h1234, 16'h0000, 32'h0);
        send_request(MODE_UNBIND, 2'd1, 16'hFFFF, 16'h1234, 16'h0000, 32'h0);    // not bound
        send_request(MODE_UNBIND, 2'd2, 16'hFFFF, 16'h1234, 16'h0000, 32'h0);
        send_request(MODE_SPARE_5, 2'd0, 16'hA5A5, 16'h0001, 16'h0001, 32'h0);
        send_request(MODE_SPARE_6, 2'd3, 16'h5A5A, 16'h0001, 16'h0001, 32'h0);
        send_request(MODE_SPARE_7, 2'd1, 16'hFFFF, 16'h0001, 16'h0001, 32'h0);
        send_request(MODE_BIND, 2'd1, 16'h0000, 16'h7777, 16'h0101, 32'h0);
        send_request(MODE_BIND, 2'd1, 16'h0001, 16'h7777, 16'h0202, 32'h0);
        send_request(MODE_ALLOC, 2'd0, 16'h0000, 16'h7777, 16'h0303, 32'h0);
        // sweep ignores the protocol and spares port 0
        send_request(MODE_UNBIND_ALL, 2'd3, 16'h0000, 16'h7777, 16'h0000, 32'h0);
        send_request(MODE_LOOKUP, 2'd1, 16'h0000, 16'h0000, 16'h0000, 32'h0);
        send_request(MODE_LOOKUP, 2'd0, EPH_LOW_RST, 16'h0000, 16'h0000, 32'h0);

        // Four-port range: exhaust it, then check old free entries keep their code
        write_settings(16'd100, 16'd103, 16'hFFFF);
        for (int i = 0; i < 5; i++)
            send_request(MODE_ALLOC, 2'd1, 16'h0BAD, 16'h0C0C, 16'(i), $urandom);
        send_request(MODE_LOOKUP, 2'd0, EPH_LOW_RST, 16'h0000, 16'h0000, 32'h0);
        send_request(MODE_LOOKUP, 2'd2, 16'h0064, 16'h0000, 16'h0000, 32'h0);

        // High below low: allocation has nothing to try
        write_settings(16'hFFFF, 16'h0000, 16'h0000);
        send_request(MODE_ALLOC, 2'd0, 16'h1111, 16'h0001, 16'h0001, 32'h0);

        // Randomised phases across idling patterns and register settings
        run_phase(0, 0, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
        run_phase(62, 0, 16'd1024, 16'd1055, 16'($urandom), 1'b1);
        run_phase(0, 62, 16'd65520, 16'hFFFF, 16'h0000, 1'b0);
        run_phase(29, 29, EPH_LOW_RST, EPH_HIGH_RST, 16'h5A5A, 1'b1);

        wait_drained();
        if (port_table.mismatch_count == 0 && port_table.outstanding() == 0)
            $display("port_allocation_table_core regression: pass");
        else
            $display("port_allocation_table_core regression: fail");
        $finish;
    end

endmodule

// ===== port_allocation_table_core.f =====
src/pat_pkg.sv
src/pat_ram.sv
src/port_allocation_table_core.sv
src/pat_checker.sv
test/tb_port_allocation_table_core.sv
